FILE: sv/bnsr_pkg.sv
`timescale 1ns / 1ps
package bnsr_pkg;

	// fixed point format of vectors and normals
	localparam int FRAC_BITS = 16;
	localparam int ONE_INT = 1 << FRAC_BITS;
	localparam int EPS_INT = (ONE_INT + 5000) / 10000;

	// bias register, unsigned q1.16
	localparam int BIAS_W = 17;
	localparam int BIAS_FRAC = 16;
	localparam logic [BIAS_W-1:0] BIAS_ONE = 17'd65536;
	localparam logic [BIAS_W-1:0] BIAS_RESET = 17'd13107;

	// internal widths
	localparam int BL_W = 33;
	localparam int U_W = FRAC_BITS + 2;
	localparam int DOT_W = 36;

	// pipeline depths
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES = FRAC_BITS + 1;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef logic signed [31:0] fix_t;
	typedef logic signed [U_W-1:0] unit_t;

	typedef struct packed {
		logic kind;
		fix_t vx;
		fix_t vy;
		fix_t vz;
	} side_t;

	typedef struct packed {
		logic  kind;
		logic  fallback;
		fix_t  vx;
		fix_t  vy;
		fix_t  vz;
		unit_t ux;
		unit_t uy;
		unit_t uz;
	} qent_t;

endpackage

FILE: sv/bnsr_if.sv
`timescale 1ns / 1ps
interface bnsr_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	modport source (output valid, kind, normal_x, normal_y, normal_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, kind, normal_x, normal_y, normal_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

interface bnsr_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic used_fallback;
	modport source (output valid, out_x, out_y, out_z, used_fallback, input ready);
	modport sink (input valid, out_x, out_y, out_z, used_fallback, output ready);
endinterface

interface bnsr_cfg_if;
	logic valid;
	logic ready;
	logic [16:0] up_bias;
	modport source (output valid, up_bias, input ready);
	modport sink (input valid, up_bias, output ready);
endinterface

FILE: sv/bnsr_sqrt.sv
`timescale 1ns / 1ps
module bnsr_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [33:0] rem_q [bnsr_pkg::SQRT_STAGES];
	logic [31:0] root_q [bnsr_pkg::SQRT_STAGES];
	logic [63:0] x_q [bnsr_pkg::SQRT_STAGES];

	logic [33:0] rem_p [bnsr_pkg::SQRT_STAGES];
	logic [31:0] root_p [bnsr_pkg::SQRT_STAGES];
	logic [63:0] x_p [bnsr_pkg::SQRT_STAGES];
	logic [35:0] cur_c [bnsr_pkg::SQRT_STAGES];
	logic [35:0] trial_c [bnsr_pkg::SQRT_STAGES];
	logic        ge_c [bnsr_pkg::SQRT_STAGES];

	// one result bit per stage, two radicand bits shifted in
	always_comb begin
		for (int k = 0; k < bnsr_pkg::SQRT_STAGES; k++) begin
			if (k == 0) begin
				rem_p[k] = '0;
				root_p[k] = '0;
				x_p[k] = radicand;
			end else begin
				rem_p[k] = rem_q[k-1];
				root_p[k] = root_q[k-1];
				x_p[k] = x_q[k-1];
			end
			cur_c[k] = {rem_p[k], x_p[k][63:62]};
			trial_c[k] = {2'b00, root_p[k], 2'b01};
			ge_c[k] = cur_c[k] >= trial_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < bnsr_pkg::SQRT_STAGES; k++) begin
				if (ge_c[k]) begin
					rem_q[k] <= 34'(cur_c[k] - trial_c[k]);
				end else begin
					rem_q[k] <= cur_c[k][33:0];
				end
				root_q[k] <= {root_p[k][30:0], ge_c[k]};
				x_q[k] <= {x_p[k][61:0], 2'b00};
			end
		end
	end

	assign root = root_q[bnsr_pkg::SQRT_STAGES-1];

endmodule

FILE: sv/bnsr_div.sv
`timescale 1ns / 1ps
module bnsr_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [31:0]                       mag,
	input  logic [31:0]                       divisor,
	output logic [bnsr_pkg::DIV_STAGES-1:0]   quot
);

	localparam int Q_W = bnsr_pkg::DIV_STAGES;

	logic [31:0]    r_q [Q_W];
	logic [31:0]    d_q [Q_W];
	logic [Q_W-1:0] q_q [Q_W];

	logic [31:0]    r_p [Q_W];
	logic [31:0]    d_p [Q_W];
	logic [Q_W-1:0] q_p [Q_W];
	logic [32:0]    cur_c [Q_W];
	logic           ge_c [Q_W];

	// restoring long division, one quotient bit per stage; the quotient
	// never exceeds one in fixed point since the magnitude is at most the divisor
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				r_p[k] = {1'b0, mag[31:1]};
				d_p[k] = divisor;
				q_p[k] = '0;
				cur_c[k] = {r_p[k], mag[0]};
			end else begin
				r_p[k] = r_q[k-1];
				d_p[k] = d_q[k-1];
				q_p[k] = q_q[k-1];
				cur_c[k] = {r_p[k], 1'b0};
			end
			ge_c[k] = cur_c[k] >= {1'b0, d_p[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				if (ge_c[k]) begin
					r_q[k] <= 32'(cur_c[k] - {1'b0, d_p[k]});
				end else begin
					r_q[k] <= cur_c[k][31:0];
				end
				d_q[k] <= d_p[k];
				q_q[k] <= {q_p[k][Q_W-2:0], ge_c[k]};
			end
		end
	end

	assign quot = q_q[Q_W-1];

endmodule

FILE: sv/bnsr_front.sv
`timescale 1ns / 1ps
module bnsr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bnsr_pkg::BIAS_W-1:0]     up_bias,
	bnsr_in_if.sink                         vec_item,
	output logic                            q_valid,
	input  logic                            q_ready,
	output bnsr_pkg::qent_t                 q_data
);

	localparam int SQ = bnsr_pkg::SQRT_STAGES;
	localparam int DV = bnsr_pkg::DIV_STAGES;
	localparam logic signed [50:0] RND_B = 51'sd1 <<< (bnsr_pkg::BIAS_FRAC - 1);

	logic en;

	// blend inputs
	logic [bnsr_pkg::BIAS_W-1:0] bias_c;
	logic [bnsr_pkg::BIAS_W-1:0] wgt_c;
	logic signed [17:0]          wgt_s;
	logic signed [50:0]          bterm_c;
	logic signed [31:0]          n_c [3];
	logic signed [49:0]          prod_c [3];
	logic signed [50:0]          acc_c [3];
	logic signed [50:0]          sh_c [3];
	bnsr_pkg::side_t             side_c;

	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [bnsr_pkg::BL_W-1:0] bl_s1 [3];
	logic signed [bnsr_pkg::BL_W-1:0] bl_s2 [3];
	logic signed [bnsr_pkg::BL_W-1:0] bl_s3 [3];
	logic [63:0]                 sq_s2 [3];
	logic [63:0]                 sum_s3;
	bnsr_pkg::side_t             side_s1, side_s2, side_s3, side_s4, side_s5;

	// alongside the square root
	logic [SQ-1:0]               sq_vld_q;
	logic signed [bnsr_pkg::BL_W-1:0] sq_bl_q [SQ][3];
	bnsr_pkg::side_t             sq_side_q [SQ];
	logic [31:0]                 len_c;

	logic                        fb_s4;
	logic [31:0]                 len_s4;
	logic [31:0]                 mag_s4 [3];
	logic [2:0]                  neg_s4;

	// alongside the dividers
	logic [DV-1:0]               dv_vld_q;
	logic [2:0]                  dv_neg_q [DV];
	logic                        dv_fb_q [DV];
	bnsr_pkg::side_t             dv_side_q [DV];
	logic [DV-1:0]               quot_c [3];

	logic                        fb_s5;
	bnsr_pkg::unit_t             u_s5 [3];

	function automatic logic [31:0] abs_mag(input logic signed [bnsr_pkg::BL_W-1:0] v);
		logic [bnsr_pkg::BL_W-1:0] a;
		a = v[bnsr_pkg::BL_W-1] ? bnsr_pkg::BL_W'(-v) : bnsr_pkg::BL_W'(v);
		return a[31:0];
	endfunction

	// whole front advances together, stalls only when the queue is full
	assign en = !vld_s5 || q_ready;
	assign vec_item.ready = en;

	always_comb begin
		bias_c = (up_bias > bnsr_pkg::BIAS_ONE) ? bnsr_pkg::BIAS_ONE : up_bias;
		wgt_c = bnsr_pkg::BIAS_ONE - bias_c;
		wgt_s = signed'({1'b0, wgt_c});
		bterm_c = signed'(51'(bias_c)) <<< bnsr_pkg::FRAC_BITS;
		n_c[0] = vec_item.normal_x;
		n_c[1] = vec_item.normal_y;
		n_c[2] = vec_item.normal_z;
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = wgt_s * n_c[i];
			acc_c[i] = 51'(prod_c[i]) + RND_B;
			if (i == 1) begin
				acc_c[i] = acc_c[i] + bterm_c;
			end
			sh_c[i] = acc_c[i] >>> bnsr_pkg::BIAS_FRAC;
		end
		side_c.kind = vec_item.kind;
		side_c.vx = vec_item.vec_x;
		side_c.vy = vec_item.vec_y;
		side_c.vz = vec_item.vec_z;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			sq_vld_q <= '0;
			vld_s4 <= 1'b0;
			dv_vld_q <= '0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vec_item.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			sq_vld_q <= {sq_vld_q[SQ-2:0], vld_s3};
			vld_s4 <= sq_vld_q[SQ-1];
			dv_vld_q <= {dv_vld_q[DV-2:0], vld_s4};
			vld_s5 <= dv_vld_q[DV-1];
		end
	end

	// blend, squares, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bl_s1[i] <= sh_c[i][bnsr_pkg::BL_W-1:0];
				bl_s2[i] <= bl_s1[i];
				sq_s2[i] <= 64'(abs_mag(bl_s1[i])) * 64'(abs_mag(bl_s1[i]));
				bl_s3[i] <= bl_s2[i];
			end
			side_s1 <= side_c;
			side_s2 <= side_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= side_s2;
		end
	end

	bnsr_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.root     (len_c)
	);

	// carry the blend beside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			sq_bl_q[0] <= bl_s3;
			sq_side_q[0] <= side_s3;
			for (int k = 1; k < SQ; k++) begin
				sq_bl_q[k] <= sq_bl_q[k-1];
				sq_side_q[k] <= sq_side_q[k-1];
			end
		end
	end

	// degenerate check and divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			fb_s4 <= len_c <= 32'(bnsr_pkg::EPS_INT);
			len_s4 <= len_c;
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= abs_mag(sq_bl_q[SQ-1][i]);
				neg_s4[i] <= sq_bl_q[SQ-1][i][bnsr_pkg::BL_W-1];
			end
			side_s4 <= sq_side_q[SQ-1];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		bnsr_div u_div (
			.clk     (clk),
			.en      (en),
			.mag     (mag_s4[i]),
			.divisor (len_s4),
			.quot    (quot_c[i])
		);
	end

	// carry signs and flag beside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			dv_neg_q[0] <= neg_s4;
			dv_fb_q[0] <= fb_s4;
			dv_side_q[0] <= side_s4;
			for (int k = 1; k < DV; k++) begin
				dv_neg_q[k] <= dv_neg_q[k-1];
				dv_fb_q[k] <= dv_fb_q[k-1];
				dv_side_q[k] <= dv_side_q[k-1];
			end
		end
	end

	// signed unit normal, or straight up when degenerate
	always_ff @(posedge clk) begin
		if (en) begin
			fb_s5 <= dv_fb_q[DV-1];
			side_s5 <= dv_side_q[DV-1];
			for (int i = 0; i < 3; i++) begin
				if (dv_fb_q[DV-1]) begin
					u_s5[i] <= (i == 1) ? bnsr_pkg::U_W'(bnsr_pkg::ONE_INT) : '0;
				end else if (dv_neg_q[DV-1][i]) begin
					u_s5[i] <= -signed'({1'b0, quot_c[i]});
				end else begin
					u_s5[i] <= signed'({1'b0, quot_c[i]});
				end
			end
		end
	end

	assign q_valid = vld_s5;
	always_comb begin
		q_data.kind = side_s5.kind;
		q_data.fallback = fb_s5;
		q_data.vx = side_s5.vx;
		q_data.vy = side_s5.vy;
		q_data.vz = side_s5.vz;
		q_data.ux = u_s5[0];
		q_data.uy = u_s5[1];
		q_data.uz = u_s5[2];
	end

endmodule

FILE: sv/bnsr_fifo.sv
`timescale 1ns / 1ps
module bnsr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bnsr_pkg::qent_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output bnsr_pkg::qent_t pop_data
);

	localparam int PW = bnsr_pkg::FIFO_PTR_W;

	bnsr_pkg::qent_t mem_q [bnsr_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign push_ready = cnt_q != (PW+1)'(bnsr_pkg::FIFO_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/bnsr_back.sv
`timescale 1ns / 1ps
module bnsr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  bnsr_pkg::qent_t q_data,
	bnsr_out_if.source      result
);

	localparam int F = bnsr_pkg::FRAC_BITS;
	localparam int P_W = 32 + bnsr_pkg::U_W;
	localparam int KD_W = bnsr_pkg::DOT_W + 1;
	localparam int M_W = KD_W + bnsr_pkg::U_W;
	localparam logic signed [P_W+1:0] RND_P = (P_W+2)'(1) <<< (F - 1);
	localparam logic signed [M_W-1:0] RND_M = M_W'(1) <<< (F - 1);
	localparam logic signed [M_W:0] OUT_MAX = (M_W+1)'(64'sd2147483647);
	localparam logic signed [M_W:0] OUT_MIN = (M_W+1)'(-64'sd2147483648);

	logic en;

	bnsr_pkg::fix_t  v_c [3];
	bnsr_pkg::unit_t u_c [3];
	bnsr_pkg::fix_t  v_b3 [3];
	bnsr_pkg::unit_t u_b1 [3];
	bnsr_pkg::unit_t u_b2 [3];

	logic                         vld_b1, vld_b2, vld_b3, vld_b4;
	bnsr_pkg::qent_t              ent_b1, ent_b2, ent_b3;
	logic signed [P_W-1:0]        prod_b1 [3];
	logic signed [P_W+1:0]        psum_c;
	logic signed [P_W+1:0]        psh_c;
	logic signed [bnsr_pkg::DOT_W-1:0] dot_b2;
	logic signed [KD_W-1:0]       kd_c;
	logic signed [M_W-1:0]        m_b3 [3];
	logic signed [M_W-1:0]        msh_c [3];
	logic signed [M_W:0]          r_c [3];
	bnsr_pkg::fix_t               res_b4 [3];
	logic                         fb_b4;

	assign en = !vld_b4 || result.ready;
	assign q_ready = en;

	always_comb begin
		v_c[0] = q_data.vx;
		v_c[1] = q_data.vy;
		v_c[2] = q_data.vz;
		u_c[0] = q_data.ux;
		u_c[1] = q_data.uy;
		u_c[2] = q_data.uz;
		u_b1[0] = ent_b1.ux;
		u_b1[1] = ent_b1.uy;
		u_b1[2] = ent_b1.uz;
		u_b2[0] = ent_b2.ux;
		u_b2[1] = ent_b2.uy;
		u_b2[2] = ent_b2.uz;
		v_b3[0] = ent_b3.vx;
		v_b3[1] = ent_b3.vy;
		v_b3[2] = ent_b3.vz;
		// dot product with rounding
		psum_c = (P_W+2)'(prod_b1[0]) + (P_W+2)'(prod_b1[1]) + (P_W+2)'(prod_b1[2]) + RND_P;
		psh_c = psum_c >>> F;
		// reflect doubles the correction
		kd_c = ent_b2.kind ? (KD_W'(dot_b2) <<< 1) : KD_W'(dot_b2);
		for (int i = 0; i < 3; i++) begin
			msh_c[i] = (m_b3[i] + RND_M) >>> F;
			r_c[i] = (M_W+1)'(v_b3[i]) - (M_W+1)'(msh_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
			vld_b2 <= 1'b0;
			vld_b3 <= 1'b0;
			vld_b4 <= 1'b0;
		end else if (en) begin
			vld_b1 <= q_valid;
			vld_b2 <= vld_b1;
			vld_b3 <= vld_b2;
			vld_b4 <= vld_b3;
		end
	end

	// products, dot, scaled normal, subtract and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			ent_b1 <= q_data;
			ent_b2 <= ent_b1;
			ent_b3 <= ent_b2;
			dot_b2 <= psh_c[bnsr_pkg::DOT_W-1:0];
			fb_b4 <= ent_b3.fallback;
			for (int i = 0; i < 3; i++) begin
				prod_b1[i] <= v_c[i] * u_c[i];
				m_b3[i] <= kd_c * u_b2[i];
				if (r_c[i] > OUT_MAX) begin
					res_b4[i] <= 32'sh7fffffff;
				end else if (r_c[i] < OUT_MIN) begin
					res_b4[i] <= 32'sh80000000;
				end else begin
					res_b4[i] <= r_c[i][31:0];
				end
			end
		end
	end

	assign result.valid = vld_b4;
	assign result.out_x = res_b4[0];
	assign result.out_y = res_b4[1];
	assign result.out_z = res_b4[2];
	assign result.used_fallback = fb_b4;

endmodule

FILE: sv/biased_normal_slide_reflect_unit.sv
`timescale 1ns / 1ps
// Blends each item's normal toward +y by up_bias, normalizes it (falling back to
// +y with used_fallback set when the blend is at most 0.0001), then slides
// (kind 0) or reflects (kind 1) the vector about it, Q16.16 with saturation.
// One item is accepted per clock and one result leaves per clock when neither
// side stalls. Items pass through the front (blend and squares, a 32 stage
// square root, a register, a 17 stage divider per axis and a register), the 4
// entry queue and the back (dot product and correction). The square root and
// dividers are fully pipelined. up_bias must be written only while the unit is
// empty; the unit itself does not enforce this. Values above 1.0 act as 1.0.
module biased_normal_slide_reflect_unit (
	input  logic       clk,
	input  logic       arst_n,
	bnsr_cfg_if.sink   cfg,
	bnsr_in_if.sink    vec_item,
	bnsr_out_if.source result
);

	logic [bnsr_pkg::BIAS_W-1:0] up_bias_q;
	logic                        q_push_valid, q_push_ready;
	logic                        q_pop_valid, q_pop_ready;
	bnsr_pkg::qent_t             q_push_data, q_pop_data;

	// bias register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_bias_q <= bnsr_pkg::BIAS_RESET;
		end else if (cfg.valid) begin
			up_bias_q <= cfg.up_bias;
		end
	end

	bnsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_bias  (up_bias_q),
		.vec_item (vec_item),
		.q_valid  (q_push_valid),
		.q_ready  (q_push_ready),
		.q_data   (q_push_data)
	);

	bnsr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	bnsr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_pop_valid),
		.q_ready (q_pop_ready),
		.q_data  (q_pop_data),
		.result  (result)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	typedef struct {
		logic kind;
		bnsr_pkg::fix_t nx, ny, nz;
		bnsr_pkg::fix_t vx, vy, vz;
	} vec_beat_t;

	typedef struct {
		bnsr_pkg::fix_t ox, oy, oz;
		logic fb;
	} res_beat_t;

	localparam int DUT_LATENCY = 59;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam longint ONE_L = 64'sd1 <<< bnsr_pkg::FRAC_BITS;
	localparam longint EPS_L = (ONE_L + 5000) / 10000;

	logic clk;
	logic arst_n;

	bnsr_cfg_if cfg_ch();
	bnsr_in_if vec_ch();
	bnsr_out_if res_ch();

	biased_normal_slide_reflect_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.vec_item(vec_ch),
		.result(res_ch)
	);

	vec_beat_t pending_vecs[$];
	res_beat_t expected_res[$];
	logic [bnsr_pkg::BIAS_W-1:0] bias_q;
	int max_gap, max_stall;
	int hold_kick, hold_seen, hold_cnt;
	int gap_cnt, stall_cnt;
	int n_sent, n_checked, n_fallback, n_errors;
	int n_reflect;
	longint cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// rounded shift, round half up
	function automatic longint rnd_shift(longint x, int k);
		return (x + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic bnsr_pkg::fix_t clamp32(longint x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return bnsr_pkg::fix_t'(x);
	endfunction

	// blended normal, then slide or reflect
	function automatic res_beat_t slide_reflect(vec_beat_t it,
		logic [bnsr_pkg::BIAS_W-1:0] bias);
		longint b, w, kf, len, dot;
		longint bl[3], u[3], v[3], n[3];
		longint unsigned sum;
		res_beat_t r;
		b = (bias > bnsr_pkg::BIAS_ONE) ? 65536 : longint'(bias);
		w = 65536 - b;
		kf = it.kind ? 2 : 1;
		n[0] = it.nx; n[1] = it.ny; n[2] = it.nz;
		v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
		bl[0] = rnd_shift(w * n[0], 16);
		bl[1] = rnd_shift(w * n[1] + b * ONE_L, 16);
		bl[2] = rnd_shift(w * n[2], 16);
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum += longint'(bl[i] < 0 ? -bl[i] : bl[i]) * longint'(bl[i] < 0 ? -bl[i] : bl[i]);
		len = int_sqrt(sum);
		r.fb = (len <= EPS_L) || (len <= 0);
		if (r.fb) begin
			u[0] = 0; u[1] = ONE_L; u[2] = 0;
		end else begin
			for (int i = 0; i < 3; i++)
				u[i] = (bl[i] * ONE_L) / len;
		end
		dot = rnd_shift(v[0] * u[0] + v[1] * u[1] + v[2] * u[2], bnsr_pkg::FRAC_BITS);
		r.ox = clamp32(v[0] - rnd_shift(kf * dot * u[0], bnsr_pkg::FRAC_BITS));
		r.oy = clamp32(v[1] - rnd_shift(kf * dot * u[1], bnsr_pkg::FRAC_BITS));
		r.oz = clamp32(v[2] - rnd_shift(kf * dot * u[2], bnsr_pkg::FRAC_BITS));
		return r;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (vec_ch.valid && vec_ch.ready) begin
				expected_res.push_back(slide_reflect('{vec_ch.kind, vec_ch.normal_x,
					vec_ch.normal_y, vec_ch.normal_z, vec_ch.vec_x, vec_ch.vec_y,
					vec_ch.vec_z}, bias_q));
				n_sent++;
				if (vec_ch.kind)
					n_reflect++;
			end
			if (!(vec_ch.valid && !vec_ch.ready)) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					vec_ch.valid <= 1'b0;
				end else if (pending_vecs.size() > 0) begin
					vec_beat_t it;
					it = pending_vecs.pop_front();
					vec_ch.valid <= 1'b1;
					vec_ch.kind <= it.kind;
					vec_ch.normal_x <= it.nx;
					vec_ch.normal_y <= it.ny;
					vec_ch.normal_z <= it.nz;
					vec_ch.vec_x <= it.vx;
					vec_ch.vec_y <= it.vy;
					vec_ch.vec_z <= it.vz;
					gap_cnt <= $urandom_range(0, max_gap);
				end else begin
					vec_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_res.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %h %h %h %b",
						$time, res_ch.out_x, res_ch.out_y, res_ch.out_z,
						res_ch.used_fallback);
					n_errors++;
				end else begin
					res_beat_t e;
					e = expected_res.pop_front();
					if (res_ch.out_x !== e.ox) begin
						$display("%0t: out_x expected %h actual %h", $time, e.ox, res_ch.out_x);
						n_errors++;
					end
					if (res_ch.out_y !== e.oy) begin
						$display("%0t: out_y expected %h actual %h", $time, e.oy, res_ch.out_y);
						n_errors++;
					end
					if (res_ch.out_z !== e.oz) begin
						$display("%0t: out_z expected %h actual %h", $time, e.oz, res_ch.out_z);
						n_errors++;
					end
					if (res_ch.used_fallback !== e.fb) begin
						$display("%0t: used_fallback expected %b actual %b", $time, e.fb,
							res_ch.used_fallback);
						n_errors++;
					end
					if (e.fb)
						n_fallback++;
				end
				n_checked++;
			end
			// receiver stalls: long hold-off on request, else short random ones
			if (hold_kick != hold_seen) begin
				hold_seen <= hold_kick;
				hold_cnt <= LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				res_ch.ready <= 1'b0;
			end else if (res_ch.valid && res_ch.ready) begin
				int s;
				s = $urandom_range(0, max_stall);
				stall_cnt <= s;
				res_ch.ready <= (s == 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				res_ch.ready <= (stall_cnt == 1);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bnsr_pkg::fix_t rand_fix();
		case ($urandom_range(0, 9))
			0, 1: return bnsr_pkg::fix_t'($urandom());
			2: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000)
				- bnsr_pkg::fix_t'($urandom_range(0, 3));
			3: return bnsr_pkg::fix_t'($urandom_range(0, 15)) - 8;
			default: return bnsr_pkg::fix_t'($urandom_range(0, 32'h80000)) - 32'sh40000;
		endcase
	endfunction

	function automatic vec_beat_t rand_vec(logic [bnsr_pkg::BIAS_W-1:0] bias);
		vec_beat_t it;
		it.kind = 1'($urandom_range(0, 1));
		it.nx = rand_fix();
		it.ny = rand_fix();
		it.nz = rand_fix();
		it.vx = rand_fix();
		it.vy = rand_fix();
		it.vz = rand_fix();
		// normal that cancels the up blend, near the fallback threshold
		if ($urandom_range(0, 9) == 0 && bias < bnsr_pkg::BIAS_ONE) begin
			it.nx = bnsr_pkg::fix_t'($urandom_range(0, 8)) - 4;
			it.nz = bnsr_pkg::fix_t'($urandom_range(0, 8)) - 4;
			it.ny = bnsr_pkg::fix_t'(-((longint'(bias) * ONE_L) / (65536 - longint'(bias))))
				+ bnsr_pkg::fix_t'($urandom_range(0, 8)) - 4;
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_vecs.size() > 0 || expected_res.size() > 0 || vec_ch.valid)
			@(posedge clk);
		repeat (DUT_LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_bias(logic [bnsr_pkg::BIAS_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.up_bias <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		bias_q = val;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_dir(logic k, bnsr_pkg::fix_t nx, bnsr_pkg::fix_t ny,
		bnsr_pkg::fix_t nz, bnsr_pkg::fix_t vx, bnsr_pkg::fix_t vy, bnsr_pkg::fix_t vz);
		pending_vecs.push_back('{k, nx, ny, nz, vx, vy, vz});
	endtask

	// stimulus sequence
	initial begin
		logic [bnsr_pkg::BIAS_W-1:0] biases[8];
		vec_beat_t held_vecs[$];
		biases = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65535,
			17'd70000, 17'd13107};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.up_bias = '0;
		vec_ch.valid = 1'b0;
		vec_ch.kind = 1'b0;
		vec_ch.normal_x = '0;
		vec_ch.normal_y = '0;
		vec_ch.normal_z = '0;
		vec_ch.vec_x = '0;
		vec_ch.vec_y = '0;
		vec_ch.vec_z = '0;
		res_ch.ready = 1'b0;
		bias_q = bnsr_pkg::BIAS_RESET;
		max_gap = 0;
		max_stall = 0;
		hold_kick = 0; hold_seen = 0; hold_cnt = 0;
		gap_cnt = 0; stall_cnt = 0;
		n_sent = 0; n_checked = 0; n_fallback = 0; n_errors = 0; n_reflect = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset bias
		push_dir(0, 0, 32'sh10000, 0, 32'sh10000, 32'sh20000, 32'sh30000);
		push_dir(1, 0, 32'sh10000, 0, 32'sh10000, 32'sh20000, 32'sh30000);
		push_dir(0, 32'sh10000, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		push_dir(1, 32'sh10000, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
		push_dir(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff);
		push_dir(1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000);
		push_dir(0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, -1, -1, -1);
		// blend cancels exactly: ny = -0.25 with bias 0.2
		push_dir(1, 0, -32'sh4000, 0, 32'sh10000, 32'sh10000, 0);
		push_dir(0, 1, -32'sh4000, -1, 32'sh10000, 32'sh10000, 0);
		wait_drained();

		// directed: zero bias, zero normal falls back
		write_bias(17'd0);
		wait_drained();
		push_dir(0, 0, 0, 0, 32'sh12345, -32'sh54321, 32'sh1);
		push_dir(1, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
		push_dir(1, 6, -6, 6, 32'sh10000, 32'sh10000, 32'sh10000);
		push_dir(1, 7, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
		push_dir(0, 0, 0, -32'sh10000, 32'sh30000, 32'sh20000, 32'sh10000);
		push_dir(1, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0);
		push_dir(0, 32'sh80000000, 0, 0, 32'sh80000000, 0, 0);
		wait_drained();

		// random phases, one per bias setting
		foreach (biases[p]) begin
			write_bias(biases[p]);
			wait_drained();
			max_gap = (p % 3 == 0) ? 0 : 10;
			max_stall = (p % 4 == 1) ? 0 : 10;
			if (p == 3) begin
				// backpressure: stop the receiver while the sender keeps going
				max_gap = 0;
				hold_kick = hold_kick + 1;
			end
			repeat (230) pending_vecs.push_back(rand_vec(bias_q));
			// sender pause mid phase until the unit is empty
			while (pending_vecs.size() > 100) @(posedge clk);
			held_vecs = pending_vecs;
			pending_vecs.delete();
			wait_drained();
			pending_vecs = held_vecs;
			max_gap = 10;
			wait_drained();
		end

		$display("checked %0d results from %0d items (%0d reflect, %0d fallback)",
			n_checked, n_sent, n_reflect, n_fallback);
		$display("bias settings covered: reset, 0, 1.0, above 1.0, and intermediates");
		if (n_errors == 0 && expected_res.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/bnsr_pkg.sv
sv/bnsr_if.sv
sv/bnsr_sqrt.sv
sv/bnsr_div.sv
sv/bnsr_front.sv
sv/bnsr_fifo.sv
sv/bnsr_back.sv
sv/biased_normal_slide_reflect_unit.sv
tb/tb_top.sv
